FILE: rtl/vlpd_pkg.sv
// Shared types and constants for the varint length packet deframer.
package vlpd_pkg;

   localparam int LENGTH_BYTES_DEF = 3;
   localparam int LEN_W            = 21;
   localparam int ID_W             = 16;
   localparam int BYTE_W           = 8;
   localparam int LIDX_W           = 3;
   localparam int SHAMT_W          = 6;
   localparam int DIGIT_W          = 7;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_ID_ONLY = 2'd1;
   localparam logic [1:0] KIND_EMPTY   = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ID_W-1:0]   packet_id;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  packet_length;
      logic              is_last;
   } vlpd_result_type;

endpackage

FILE: rtl/vlpd_core.sv
// Framing state machine: varint length decode, ID capture and payload tagging.
module vlpd_core #(
   parameter int LENGTH_BYTES = vlpd_pkg::LENGTH_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [vlpd_pkg::BYTE_W-1:0]  stream_byte,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   output logic                         res_valid,
   output vlpd_pkg::vlpd_result_type    res
);
   import vlpd_pkg::*;

   typedef enum logic [1:0] {
      PH_LENGTH  = 2'd0,
      PH_ID      = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [LEN_W-1:0]   acc_ff, acc_in;
   logic [LIDX_W-1:0]  lidx_ff, lidx_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic               id_idx_ff, id_idx_in;
   logic               wide_ff;

   logic [SHAMT_W-1:0] shamt;
   logic [LEN_W-1:0]   part;
   logic [LEN_W-1:0]   acc_new;
   logic [LIDX_W-1:0]  lidx_inc;
   logic [LEN_W-1:0]   rem_dec;
   logic [ID_W-1:0]    id_shift;

   assign shamt    = SHAMT_W'(lidx_ff) * SHAMT_W'(DIGIT_W);
   assign part     = {{(LEN_W-DIGIT_W){1'b0}}, stream_byte[DIGIT_W-1:0]} << shamt;
   assign acc_new  = acc_ff | part;
   assign lidx_inc = lidx_ff + LIDX_W'(1);
   assign rem_dec  = rem_ff - LEN_W'(1);
   assign id_shift = {id_ff[ID_W-BYTE_W-1:0], stream_byte};

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      lidx_in   = lidx_ff;
      rem_in    = rem_ff;
      id_in     = id_ff;
      id_idx_in = id_idx_ff;
      res_valid = 1'b0;
      res       = '0;
      res.is_last = 1'b1;
      unique case (phase_ff)
         PH_ID: begin
            id_in  = id_shift;
            rem_in = rem_dec;
            if (wide_ff && !id_idx_ff) begin
               if (rem_dec == '0) begin
                  res_valid         = 1'b1;
                  res.kind          = KIND_ERROR;
                  res.packet_length = acc_ff;
               end else begin
                  id_idx_in = 1'b1;
               end
            end else if (rem_dec == '0) begin
               res_valid         = 1'b1;
               res.kind          = KIND_ID_ONLY;
               res.packet_id     = id_shift;
               res.packet_length = acc_ff;
            end else begin
               phase_in = PH_PAYLOAD;
            end
            // Drop back to length parsing after any result here.
            if (res_valid) begin
               phase_in  = PH_LENGTH;
               acc_in    = '0;
               lidx_in   = '0;
               rem_in    = '0;
               id_idx_in = 1'b0;
            end
         end
         PH_PAYLOAD: begin
            rem_in            = rem_dec;
            res_valid         = 1'b1;
            res.kind          = KIND_PAYLOAD;
            res.packet_id     = id_ff;
            res.data_byte     = stream_byte;
            res.packet_length = acc_ff;
            res.is_last       = (rem_dec == '0);
            if (rem_dec == '0) begin
               phase_in  = PH_LENGTH;
               acc_in    = '0;
               lidx_in   = '0;
               id_idx_in = 1'b0;
            end
         end
         default: begin
            phase_in = PH_LENGTH;
            acc_in   = acc_new;
            lidx_in  = lidx_inc;
            if (stream_byte[BYTE_W-1]) begin
               // Varint too long: report what was decoded so far.
               if (lidx_inc >= LIDX_W'(LENGTH_BYTES)) begin
                  res_valid         = 1'b1;
                  res.kind          = KIND_ERROR;
                  res.packet_length = acc_new;
               end
            end else if (acc_new == '0) begin
               res_valid = 1'b1;
               res.kind  = KIND_EMPTY;
            end else if (wide_ff && acc_new == LEN_W'(1)) begin
               res_valid         = 1'b1;
               res.kind          = KIND_ERROR;
               res.packet_length = acc_new;
            end else begin
               phase_in  = PH_ID;
               rem_in    = acc_new;
               id_in     = '0;
               id_idx_in = 1'b0;
               lidx_in   = '0;
            end
            if (res_valid) begin
               acc_in    = '0;
               lidx_in   = '0;
               rem_in    = '0;
               id_idx_in = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LENGTH;
         acc_ff    <= '0;
         lidx_ff   <= '0;
         rem_ff    <= '0;
         id_ff     <= '0;
         id_idx_ff <= 1'b0;
         wide_ff   <= 1'b0;
      end else begin
         if (step) begin
            phase_ff  <= phase_in;
            acc_ff    <= acc_in;
            lidx_ff   <= lidx_in;
            rem_ff    <= rem_in;
            id_ff     <= id_in;
            id_idx_ff <= id_idx_in;
         end
         if (csr_wr_en) begin
            wide_ff <= csr_wr_data;
         end
      end
   end

endmodule

FILE: rtl/vlpd_out_buf.sv
// Result register with a one-entry skid stage.
module vlpd_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  vlpd_pkg::vlpd_result_type push_data,
   output logic                      full,
   output logic                      out_valid,
   input  logic                      out_stall,
   output vlpd_pkg::vlpd_result_type out_data
);
   import vlpd_pkg::*;

   logic            out_valid_ff;
   vlpd_result_type out_ff;
   logic            skid_valid_ff;
   vlpd_result_type skid_ff;
   logic            pop;

   assign pop       = out_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff <= push_data;
         end else begin
            skid_ff <= push_data;
         end
      end
   end

endmodule

FILE: rtl/varint_length_packet_deframer.sv
// Top level of the varint length-prefixed packet deframer.
//
// Usage: stream link bytes in on req_ (valid/stall), one byte per request.
// Each packet is a little-endian base-128 varint length, then a one- or
// two-byte big-endian ID (csr_wr_data written with csr_wr_en selects the
// two-byte form), then payload. Results leave on rsp_: one per payload byte,
// or one for an ID-only packet, an empty packet, or a framing error.
// Length and ID bytes yield a result only for an empty or ID-only packet or an error.
// Throughput: one request per cycle sustained while req_stall is low; the
// framing state is updated by combinational logic behind the state registers.
// Each result is registered: in the skid entry if the result register holds.
// Receiver stall: the result register holds, a skid entry absorbs one more
// result, and req_stall is high while the skid entry is full.
// Reset (synchronous): length parsing restarts, the ID is cleared, the ID
// width goes to one byte and both result entries are emptied.
module varint_length_packet_deframer #(
   parameter int LENGTH_BYTES = vlpd_pkg::LENGTH_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [vlpd_pkg::BYTE_W-1:0]  req_stream_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_kind,
   output logic [vlpd_pkg::ID_W-1:0]    rsp_packet_id,
   output logic [vlpd_pkg::BYTE_W-1:0]  rsp_data_byte,
   output logic [vlpd_pkg::LEN_W-1:0]   rsp_packet_length,
   output logic                         rsp_is_last,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data
);
   import vlpd_pkg::*;

   logic            step;
   logic            res_valid;
   vlpd_result_type res;
   logic            buf_full;
   vlpd_result_type out_data;

   // Advance the framer only on an accepted request.
   assign req_stall = buf_full;
   assign step      = req_valid && !buf_full;

   vlpd_core #(
      .LENGTH_BYTES(LENGTH_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .stream_byte (req_stream_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .res_valid   (res_valid),
      .res         (res)
   );

   vlpd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (step && res_valid),
      .push_data (res),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_kind          = out_data.kind;
   assign rsp_packet_id     = out_data.packet_id;
   assign rsp_data_byte     = out_data.data_byte;
   assign rsp_packet_length = out_data.packet_length;
   assign rsp_is_last       = out_data.is_last;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the varint length packet deframer.
module tb_top;
   import vlpd_pkg::*;

   localparam int CLOCK_PERIOD     = 10;
   localparam int RESET_CYCLES     = 12;
   localparam int RANDOM_BYTES     = 1870;
   localparam int RANDOM_PHASES    = 8;
   // result register plus skid entry: the settle time covers anything still in flight
   localparam int SETTLE_CYCLES    = 4;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int REPORT_LIMIT     = 10;

   typedef enum logic [1:0] {PH_LENGTH, PH_ID, PH_PAYLOAD} frame_phase_type;
   typedef enum logic [1:0] {ROW_SEND, ROW_SEND_CHECKED, ROW_SET_WIDE} row_op_type;

   // One line of the directed table: a stream byte, a stream byte with its
   // result typed in by hand, or a write of the ID width.
   typedef struct packed {
      row_op_type        op;
      logic [BYTE_W-1:0] value;
      vlpd_result_type   result;
   } stim_row_type;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_stream_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall       = 1'b0;
   logic [1:0]        rsp_kind;
   logic [ID_W-1:0]   rsp_packet_id;
   logic [BYTE_W-1:0] rsp_data_byte;
   logic [LEN_W-1:0]  rsp_packet_length;
   logic              rsp_is_last;
   logic              csr_wr_en       = 1'b0;
   logic              csr_wr_data     = 1'b0;

   // Gap controls: tx_idle for the sender, rx_idle and long_hold_req for the receiver.
   logic tx_idle       = 1'b1;
   logic rx_idle       = 1'b1;
   logic long_hold_req = 1'b0;

   // Deframer state as the predictor sees it.
   frame_phase_type   frm_phase;
   logic              wide_mode;
   logic [LEN_W-1:0]  len_acc;
   logic [LIDX_W-1:0] len_idx;
   logic [LEN_W-1:0]  bytes_left;
   logic [ID_W-1:0]   id_reg;
   logic              id_second;

   vlpd_result_type pending_results[$];
   stim_row_type    directed_rows[$];

   int unsigned bytes_sent      = 0;
   int unsigned results_checked = 0;
   int unsigned wide_writes     = 0;
   int unsigned failures        = 0;
   int unsigned cycle_count     = 0;
   int unsigned kind_count [4]  = '{0, 0, 0, 0};

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   varint_length_packet_deframer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_stream_byte   (req_stream_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_packet_id     (rsp_packet_id),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_packet_length (rsp_packet_length),
      .rsp_is_last       (rsp_is_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Go back to length parsing; the ID register keeps its value.
   function automatic void restart_framing();
      frm_phase  = PH_LENGTH;
      len_acc    = '0;
      len_idx    = '0;
      bytes_left = '0;
      id_second  = 1'b0;
   endfunction

   // Advance the framing state by one stream byte; return 1 when the byte
   // produces a result, which is then left in r.
   function automatic logic deframe_byte(input logic [BYTE_W-1:0] b,
                                         output vlpd_result_type r);
      logic [63:0] digit;
      r         = '0;
      r.is_last = 1'b1;

      if (frm_phase == PH_ID) begin
         id_reg     = {id_reg[7:0], b};
         bytes_left = bytes_left - LEN_W'(1);
         // the first byte of a two-byte ID; wide_mode is looked at on every ID byte
         if (wide_mode && !id_second) begin
            if (bytes_left == '0) begin
               r.kind          = KIND_ERROR;
               r.packet_length = len_acc;
               restart_framing();
               return 1'b1;
            end
            id_second = 1'b1;
            return 1'b0;
         end
         if (bytes_left == '0) begin
            r.kind          = KIND_ID_ONLY;
            r.packet_id     = id_reg;
            r.packet_length = len_acc;
            restart_framing();
            return 1'b1;
         end
         frm_phase = PH_PAYLOAD;
         return 1'b0;
      end

      if (frm_phase == PH_PAYLOAD) begin
         bytes_left      = bytes_left - LEN_W'(1);
         r.kind          = KIND_PAYLOAD;
         r.packet_id     = id_reg;
         r.data_byte     = b;
         r.packet_length = len_acc;
         r.is_last       = (bytes_left == '0);
         if (r.is_last) restart_framing();
         return 1'b1;
      end

      // length byte: fold in seven more bits, little-endian
      digit   = 64'(b[DIGIT_W-1:0]) << (DIGIT_W * len_idx);
      len_acc = len_acc | digit[LEN_W-1:0];
      len_idx = len_idx + LIDX_W'(1);
      if (b[7]) begin
         if (len_idx >= LENGTH_BYTES_DEF) begin
            r.kind          = KIND_ERROR;
            r.packet_length = len_acc;
            restart_framing();
            return 1'b1;
         end
         return 1'b0;
      end
      if (len_acc == '0) begin
         r.kind = KIND_EMPTY;
         restart_framing();
         return 1'b1;
      end
      if (wide_mode && len_acc == LEN_W'(1)) begin
         r.kind          = KIND_ERROR;
         r.packet_length = len_acc;
         restart_framing();
         return 1'b1;
      end
      frm_phase  = PH_ID;
      bytes_left = len_acc;
      id_reg     = '0;
      id_second  = 1'b0;
      len_idx    = '0;
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Directed table rows
   // ---------------------------------------------------------------------

   function automatic stim_row_type send_row(input logic [BYTE_W-1:0] value);
      stim_row_type row;
      row       = '0;
      row.op    = ROW_SEND;
      row.value = value;
      return row;
   endfunction

   // Hand-typed results here are all final results with no data byte.
   function automatic stim_row_type checked_row(input logic [BYTE_W-1:0] value,
                                                input logic [1:0] kind,
                                                input logic [ID_W-1:0] id,
                                                input logic [LEN_W-1:0] len);
      stim_row_type row;
      row                      = '0;
      row.op                   = ROW_SEND_CHECKED;
      row.value                = value;
      row.result.kind          = kind;
      row.result.packet_id     = id;
      row.result.packet_length = len;
      row.result.is_last       = 1'b1;
      return row;
   endfunction

   function automatic stim_row_type wide_row(input logic value);
      stim_row_type row;
      row       = '0;
      row.op    = ROW_SET_WIDE;
      row.value = {7'd0, value};
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Offer one byte after a random gap if tx_idle, hold it until accepted, then
   // record what it should produce: the typed result if given, else the prediction.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic checked,
                            input vlpd_result_type typed_result);
      int unsigned     gap;
      logic            produced;
      vlpd_result_type predicted;
      gap = tx_idle ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      produced = deframe_byte(b, predicted);
      if (checked) pending_results.push_back(typed_result);
      else if (produced) pending_results.push_back(predicted);
   endtask

   // Write the ID width only with nothing in flight: drop valid, drain every
   // pending result, let the pipeline settle, then pulse the write enable.
   task automatic write_wide_id(input logic value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      wide_mode = value;
      wide_writes++;
   endtask

   // Send one packet with random length, ID and payload. Most lengths are
   // small; a few need a two-byte varint. Now and then pad the varint with
   // continuation bytes up to the three-byte maximum.
   task automatic send_packet();
      int unsigned      pick;
      int unsigned      len;
      int unsigned      groups;
      int unsigned      fewest;
      logic [LEN_W-1:0] rest;
      pick = $urandom_range(0, 99);
      if (pick < 8) len = 0;
      else if (pick < 18) len = $urandom_range(1, 2);
      else if (pick < 85) len = $urandom_range(3, 16);
      else if (pick < 96) len = $urandom_range(17, 60);
      else len = $urandom_range(128, 300);
      fewest = (len >= 128) ? 2 : 1;
      groups = ($urandom_range(0, 7) == 0) ?
               $urandom_range(fewest, LENGTH_BYTES_DEF) : fewest;
      rest   = LEN_W'(len);
      for (int g = 0; g < groups; g++) begin
         send_byte({(g + 1 < groups), rest[DIGIT_W-1:0]}, 1'b0, '0);
         rest = rest >> DIGIT_W;
      end
      for (int k = 0; k < len; k++)
         send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   // ---------------------------------------------------------------------
   // Receiver side
   // ---------------------------------------------------------------------

   // Draw a random stall before each result while rx_idle; once, on request, hold
   // off for a long stretch so the skid entry fills and the input stalls.
   initial begin : receiver
      int unsigned wait_cycles;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         wait_cycles = rx_idle ? $urandom_range(0, 3) : 0;
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   function automatic void flag_failure(input string what, input vlpd_result_type want,
                                        input vlpd_result_type got);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("%0t %s: expected kind=%0d id=%h data=%h len=%h last=%0d",
                  $time, what, want.kind, want.packet_id, want.data_byte,
                  want.packet_length, want.is_last);
         $display("%0t %s: got      kind=%0d id=%h data=%h len=%h last=%0d",
                  $time, what, got.kind, got.packet_id, got.data_byte,
                  got.packet_length, got.is_last);
      end
   endfunction

   // Compare each accepted result with the oldest pending one, field by field.
   always @(posedge clock) begin : result_check
      vlpd_result_type seen;
      vlpd_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_kind, rsp_packet_id, rsp_data_byte, rsp_packet_length, rsp_is_last};
         if (pending_results.size() == 0) begin
            flag_failure("result with none pending", '0, seen);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            kind_count[want.kind]++;
            if (seen.kind !== want.kind || seen.packet_id !== want.packet_id ||
                seen.data_byte !== want.data_byte ||
                seen.packet_length !== want.packet_length || seen.is_last !== want.is_last)
               flag_failure("result mismatch", want, seen);
         end
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results pending", cycle_count,
                  pending_results.size());
         $display("varint_length_packet_deframer verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   initial begin : stimulus
      int unsigned phase_end;
      int unsigned pick;

      wide_mode = 1'b0;
      id_reg    = '0;
      restart_framing();

      // Directed table, starting from the one-byte ID of reset.
      // Empty packet, plain and with a padded zero length.
      directed_rows.push_back(checked_row(8'h00, KIND_EMPTY, 16'h0000, 21'h000000));
      directed_rows.push_back(send_row(8'h80));
      directed_rows.push_back(checked_row(8'h00, KIND_EMPTY, 16'h0000, 21'h000000));
      // ID-only packet with an all-ones ID byte.
      directed_rows.push_back(send_row(8'h01));
      directed_rows.push_back(checked_row(8'hFF, KIND_ID_ONLY, 16'h00FF, 21'h000001));
      // Short packet carrying the two extreme payload bytes.
      directed_rows.push_back(send_row(8'h03));
      directed_rows.push_back(send_row(8'hA5));
      directed_rows.push_back(send_row(8'h00));
      directed_rows.push_back(send_row(8'hFF));
      // Varint too long: high bits only, then all ones.
      directed_rows.push_back(send_row(8'h80));
      directed_rows.push_back(send_row(8'h80));
      directed_rows.push_back(checked_row(8'hFF, KIND_ERROR, 16'h0000, 21'h1FC000));
      directed_rows.push_back(send_row(8'hFF));
      directed_rows.push_back(send_row(8'hFF));
      directed_rows.push_back(checked_row(8'hFF, KIND_ERROR, 16'h0000, 21'h1FFFFF));
      // Two-byte ID: too short, ID-only with all-ones ID, one payload byte.
      directed_rows.push_back(wide_row(1'b1));
      directed_rows.push_back(checked_row(8'h01, KIND_ERROR, 16'h0000, 21'h000001));
      directed_rows.push_back(send_row(8'h02));
      directed_rows.push_back(send_row(8'hFF));
      directed_rows.push_back(checked_row(8'hFF, KIND_ID_ONLY, 16'hFFFF, 21'h000002));
      directed_rows.push_back(send_row(8'h03));
      directed_rows.push_back(send_row(8'h12));
      directed_rows.push_back(send_row(8'h34));
      directed_rows.push_back(send_row(8'h5A));
      // Switch to the two-byte ID once a one-byte packet has its length:
      // its single ID byte is then too short.
      directed_rows.push_back(wide_row(1'b0));
      directed_rows.push_back(send_row(8'h01));
      directed_rows.push_back(wide_row(1'b1));
      directed_rows.push_back(checked_row(8'h77, KIND_ERROR, 16'h0000, 21'h000001));
      // Drop back to the one-byte ID after the first of two ID bytes.
      directed_rows.push_back(send_row(8'h03));
      directed_rows.push_back(send_row(8'hAB));
      directed_rows.push_back(wide_row(1'b0));
      directed_rows.push_back(send_row(8'hCD));
      directed_rows.push_back(send_row(8'hEE));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == ROW_SET_WIDE)
            write_wide_id(directed_rows[i].value[0]);
         else
            send_byte(directed_rows[i].value, directed_rows[i].op == ROW_SEND_CHECKED,
                      directed_rows[i].result);
      end

      // Random phases. Each opens with an ID-width write, so the sender also
      // pauses until every pending result has come back. Some phases run
      // one side or the other without gaps; one pairs a nonstop sender with
      // a long receiver hold.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_wide_id((ph % 2) != 0);
         tx_idle = (ph != 2 && ph != 5);
         rx_idle = (ph != 3 && ph != 6);
         if (ph == 5) long_hold_req = 1'b1;
         phase_end = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
         while (bytes_sent < phase_end) begin
            // realign on a packet boundary after noise swallowed the stream
            while (frm_phase != PH_LENGTH || len_idx != '0)
               send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               send_packet();
            end else if (pick < 88) begin
               // overlong varint with random digits
               repeat (LENGTH_BYTES_DEF)
                  send_byte({1'b1, 7'($urandom_range(0, 127))}, 1'b0, '0);
            end else if (pick < 94) begin
               // stray byte, read as a short length
               send_byte(BYTE_W'($urandom_range(0, 127)), 1'b0, '0);
            end else begin
               // length of one: an ID-only packet or too short for a wide ID
               send_byte(8'h01, 1'b0, '0);
               send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
            end
         end
      end

      // Drain, then wait twice the settle time for any stray result to show.
      req_valid <= 1'b0;
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);

      $display("Ran %0d stream bytes across %0d ID-width writes in %0d cycles;",
               bytes_sent, wide_writes, cycle_count);
      $display("%0d results checked: %0d payload, %0d ID-only, %0d empty, %0d error; %0d failures",
               results_checked, kind_count[KIND_PAYLOAD], kind_count[KIND_ID_ONLY],
               kind_count[KIND_EMPTY], kind_count[KIND_ERROR], failures);
      if (failures == 0)
         $display("varint_length_packet_deframer verification clean");
      else
         $display("varint_length_packet_deframer verification failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/vlpd_pkg.sv
rtl/vlpd_core.sv
rtl/vlpd_out_buf.sv
rtl/varint_length_packet_deframer.sv
tb/tb_top.sv
